// File: sv/bsim_pkg.sv
`default_nettype none

package bsim_pkg;

  // Field types of the two channels
  typedef logic [1:0]  op_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] cycles_t;
  typedef logic [2:0]  kind_t;
  typedef logic [2:0]  slot_t;

  // Operation codes
  localparam op_t OP_INIT  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  // Event kinds
  localparam kind_t EV_NONE   = 3'd0;
  localparam kind_t EV_PRG    = 3'd1;
  localparam kind_t EV_CHR    = 3'd2;
  localparam kind_t EV_MIRROR = 3'd3;
  localparam kind_t EV_IRQ    = 3'd4;
  localparam kind_t EV_ACK    = 3'd5;

  // Write decode
  localparam addr_t ADDR_CHR_MASK = 16'hFFF8;
  localparam addr_t ADDR_CHR_BASE = 16'hB000;
  localparam addr_t ADDR_PRG0     = 16'h8000;
  localparam addr_t ADDR_PRG1     = 16'hA000;
  localparam addr_t ADDR_PRG2     = 16'hC000;
  localparam addr_t ADDR_MIRROR   = 16'h9001;
  localparam addr_t ADDR_IRQ_CTRL = 16'h9003;
  localparam addr_t ADDR_IRQ_LOAD = 16'h9004;
  localparam addr_t ADDR_RELOAD_H = 16'h9005;
  localparam addr_t ADDR_RELOAD_L = 16'h9006;

  // Interrupt counter
  localparam int unsigned CntW = 18;
  localparam logic signed [CntW-1:0] IRQ_FLOOR = -18'sd4;
  localparam logic signed [CntW-1:0] IRQ_PARK  = -18'sd1;

  // Init sequence
  localparam int unsigned InitEvents = 13;
  localparam logic [3:0] INIT_LAST = 4'(InitEvents - 1);

  // Config register indexes
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_MIRROR    = 1'b1;

  typedef struct packed {
    kind_t kind;
    slot_t slot;
    byte_t value;
  } ev_t;

  // One event of the init burst: four prg windows, eight chr windows, mirroring
  function automatic ev_t init_event(input logic [3:0] idx, input logic [8:0] count,
                                     input logic mirror_vertical);
    ev_t ev;
    ev = '{kind: EV_NONE, slot: 3'd0, value: 8'd0};
    if (idx < 4'd4) begin
      ev.kind = EV_PRG;
      ev.slot = idx[2:0];
      if (idx == 4'd2) begin
        ev.value = count[7:0] - 8'd2;
      end else if (idx == 4'd3) begin
        ev.value = count[7:0] - 8'd1;
      end
    end else if (idx < INIT_LAST) begin
      ev.kind = EV_CHR;
      ev.slot = 3'(idx - 4'd4);
    end else begin
      ev.kind  = EV_MIRROR;
      ev.value = {7'd0, ~mirror_vertical};
    end
    return ev;
  endfunction

endpackage

`default_nettype wire

// File: sv/bsim_if.sv
`default_nettype none

interface bsim_in_if import bsim_pkg::*;;
  logic    valid;
  logic    ready;
  op_t     operation;
  addr_t   bus_address;
  byte_t   write_data;
  cycles_t tick_cycles;

  modport source (output valid, operation, bus_address, write_data, tick_cycles,
                  input ready);
  modport sink   (input valid, operation, bus_address, write_data, tick_cycles,
                  output ready);
endinterface

interface bsim_out_if import bsim_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t event_kind;
  slot_t slot;
  byte_t value;
  logic  last;

  modport source (output valid, event_kind, slot, value, last, input ready);
  modport sink   (input valid, event_kind, slot, value, last, output ready);
endinterface

`default_nettype wire

// File: sv/bank_switch_irq_mapper_unit.sv
// Bank-switching mapper with a cycle-counting interrupt.
// Input channel in_i carries one item per transfer: init, bus write or clock
// tick. Output channel out_o returns the events that item causes, the last
// one flagged by last. Init gives thirteen events, every other item one.
// The APB port holds the program bank count (address 0) and the start
// mirroring (address 4); write it only while the block is idle.
// A simple write or tick goes from decode to the output register; a program
// bank write first computes the remainder by the bank count, which runs through
// one shared 18-bit subtractor, one quotient bit per cycle. The same
// subtractor applies tick cycles to the interrupt counter. Init streams one
// event per cycle from the cycle after decode while the receiver keeps up.
// One item is in flight at a time: in_i.ready is high only while the
// sequencer is idle, so no new item is taken before the last one is through.
// The output register lets the next item be taken while a result waits.
// Reset clears the interrupt state, the sequencer and the output valid, and
// sets the bank count to 2 and mirroring to horizontal. A stalled receiver
// holds the output register; the sequencer waits with its result.
`default_nettype none

module bank_switch_irq_mapper_unit import bsim_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  bsim_in_if.sink     in_i,
  bsim_out_if.source  out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration
  logic [8:0] prg_count_q;
  logic       mirror_v_q;
  logic       cfg_wr;

  // Captured item
  op_t     op_q;
  addr_t   addr_q;
  byte_t   data_q;
  cycles_t cycles_q;

  // Interrupt state
  logic                   irq_en_q, irq_en_d;
  logic signed [CntW-1:0] irq_cnt_q, irq_cnt_d;
  logic [15:0]            reload_q, reload_d;

  // Divider and init burst
  logic [8:0] rem_q, rem_d;
  logic [2:0] bit_q, bit_d;
  logic [3:0] idx_q, idx_d;
  logic [8:0] shifted;

  // Pending single result
  ev_t res_q, res_d;

  // Output register
  logic  out_valid_q, out_valid_d;
  ev_t   out_ev_q, out_ev_d;
  logic  out_last_q, out_last_d;
  logic  out_free;
  ev_t   init_ev;

  // Shared subtractor
  logic signed [CntW-1:0] sub_a, sub_b, sub_y;

  assign sub_y = sub_a - sub_b;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MIRROR) ? {31'd0, mirror_v_q} : {23'd0, prg_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= 9'd2;
      mirror_v_q  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PRG_COUNT) begin
        prg_count_q <= pwdata[8:0];
      end else begin
        mirror_v_q <= pwdata[0];
      end
    end
  end

  // Channels
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_ev_q.kind;
  assign out_o.slot       = out_ev_q.slot;
  assign out_o.value      = out_ev_q.value;
  assign out_o.last       = out_last_q;
  assign out_free         = !out_valid_q || out_o.ready;

  assign shifted = {rem_q[7:0], data_q[bit_q]};
  assign init_ev = init_event(idx_q, prg_count_q, mirror_v_q);

  always_comb begin
    state_d     = state_q;
    irq_en_d    = irq_en_q;
    irq_cnt_d   = irq_cnt_q;
    reload_d    = reload_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;
    sub_a       = irq_cnt_q;
    sub_b       = {2'd0, cycles_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '{kind: EV_NONE, slot: 3'd0, value: 8'd0};
        state_d = S_PUT;
        case (op_q)
          OP_INIT: begin
            irq_en_d  = 1'b0;
            irq_cnt_d = '0;
            reload_d  = '0;
            idx_d     = '0;
            state_d   = S_INIT;
          end
          OP_WRITE: begin
            if ((addr_q & ADDR_CHR_MASK) == ADDR_CHR_BASE) begin
              res_d = '{kind: EV_CHR, slot: addr_q[2:0], value: data_q};
            end else if (addr_q == ADDR_PRG0 || addr_q == ADDR_PRG1 ||
                         addr_q == ADDR_PRG2) begin
              res_d.kind  = EV_PRG;
              res_d.slot  = (addr_q == ADDR_PRG0) ? 3'd0 :
                            (addr_q == ADDR_PRG1) ? 3'd1 : 3'd2;
              res_d.value = data_q;
              // zero count passes the data through
              if (prg_count_q != 9'd0) begin
                rem_d   = '0;
                bit_d   = 3'd7;
                state_d = S_DIV;
              end
            end else if (addr_q == ADDR_MIRROR) begin
              res_d = '{kind: EV_MIRROR, slot: 3'd0, value: {7'd0, data_q[7]}};
            end else if (addr_q == ADDR_IRQ_CTRL) begin
              irq_en_d   = data_q[7];
              res_d.kind = EV_ACK;
            end else if (addr_q == ADDR_IRQ_LOAD) begin
              irq_cnt_d = {2'd0, reload_q};
            end else if (addr_q == ADDR_RELOAD_H) begin
              reload_d = {data_q, reload_q[7:0]};
            end else if (addr_q == ADDR_RELOAD_L) begin
              reload_d = {reload_q[15:8], data_q};
            end
          end
          OP_TICK: begin
            if (irq_en_q) begin
              if (sub_y < IRQ_FLOOR) begin
                irq_en_d   = 1'b0;
                irq_cnt_d  = IRQ_PARK;
                res_d.kind = EV_IRQ;
              end else begin
                irq_cnt_d = sub_y;
              end
            end
          end
          default: ;
        endcase
      end

      S_DIV: begin
        // restoring remainder, one dividend bit per cycle
        sub_a = {9'd0, shifted};
        sub_b = {9'd0, prg_count_q};
        rem_d = sub_y[CntW-1] ? shifted : sub_y[8:0];
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          res_d.value = rem_d[7:0];
          state_d     = S_PUT;
        end
      end

      S_PUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = res_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_INIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = init_ev;
          out_last_d  = (idx_q == INIT_LAST);
          idx_d       = idx_q + 4'd1;
          if (idx_q == INIT_LAST) begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      irq_en_q    <= 1'b0;
      irq_cnt_q   <= '0;
      reload_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      irq_en_q    <= irq_en_d;
      irq_cnt_q   <= irq_cnt_d;
      reload_q    <= reload_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q     <= in_i.operation;
      addr_q   <= in_i.bus_address;
      data_q   <= in_i.write_data;
      cycles_q <= in_i.tick_cycles;
    end
    rem_q      <= rem_d;
    res_q      <= res_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

  // The counter is parked as soon as it would drop below the floor
  a_cnt_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_cnt_q >= IRQ_FLOOR)
    else $error("interrupt counter below floor");

  // Init clears the enable and nothing touches it during the burst
  a_init_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !irq_en_q)
    else $error("interrupt enabled during init burst");

  // Divider ends only in the result hand-off
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |=> state_q == S_DIV || state_q == S_PUT)
    else $error("divider left to wrong state");

  // A pending result lands in the output register once it is free
  a_put_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT && out_free |=> out_valid_q && out_last_q)
    else $error("pending result not registered");

  // The sequencer only takes an item while idle
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> $past(in_i.valid) && $past(state_q) == S_IDLE)
    else $error("decode without a transfer");

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
  import bsim_pkg::*;

  // Operation code that the block answers with a single empty event
  localparam op_t OP_RESERVED = 2'd3;
  // Run limit; a clean run needs a small fraction of it
  localparam int CycleLimit = 250000;
  // Length of the long receiver hold-off, in cycles
  localparam int HoldoffCycles = 150;

  // One bus-side item as the sender offers it
  typedef struct {
    op_t     op;
    addr_t   addr;
    byte_t   data;
    cycles_t cycles;
  } bus_item_t;

  // One event as the block should return it
  typedef struct {
    kind_t kind;
    slot_t slot;
    byte_t value;
    logic  last;
  } map_event_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bsim_in_if  map_in ();
  bsim_out_if map_out ();

  bank_switch_irq_mapper_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (map_in),
    .out_o   (map_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Items waiting to be offered, and events still owed by the block
  bus_item_t  bus_items[$];
  map_event_t due_events[$];

  // Predictor copy of the configuration and of the interrupt state.
  // The bank registers never show up on the output, so they are not kept.
  logic [8:0]  bank_count = 9'd2;
  logic        mirror_vertical = 1'b0;
  logic        irq_armed = 1'b0;
  int          irq_tally = 0;
  logic [15:0] reload_value = 16'd0;

  int error_count = 0;
  int items_taken = 0;
  int events_checked = 0;
  int irqs_seen = 0;
  int settings_used = 1;
  int cycle_count = 0;

  // Sender burst state and receiver stall state
  int send_gap = 0;
  int burst_left = 1;
  int run_left = 0;
  int stall_left = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  task automatic push_event(input kind_t kind, input slot_t slot, input byte_t value,
                            input logic last);
    map_event_t ev;
    ev.kind  = kind;
    ev.slot  = slot;
    ev.value = value;
    ev.last  = last;
    due_events.push_back(ev);
  endtask

  // Work out the events one accepted item causes and advance the state
  task automatic map_events(input bus_item_t it);
    logic raised;
    raised = 1'b0;
    case (it.op)
      OP_INIT: begin
        irq_armed    = 1'b0;
        irq_tally    = 0;
        reload_value = 16'd0;
        push_event(EV_PRG, 3'd0, 8'd0, 1'b0);
        push_event(EV_PRG, 3'd1, 8'd0, 1'b0);
        push_event(EV_PRG, 3'd2, 8'(bank_count - 9'd2), 1'b0);
        push_event(EV_PRG, 3'd3, 8'(bank_count - 9'd1), 1'b0);
        for (int s = 0; s < 8; s++) begin
          push_event(EV_CHR, slot_t'(s), 8'd0, 1'b0);
        end
        push_event(EV_MIRROR, 3'd0, {7'd0, ~mirror_vertical}, 1'b1);
      end
      OP_WRITE: begin
        if ((it.addr & ADDR_CHR_MASK) == ADDR_CHR_BASE) begin
          push_event(EV_CHR, it.addr[2:0], it.data, 1'b1);
        end else if (it.addr == ADDR_PRG0 || it.addr == ADDR_PRG1 ||
                     it.addr == ADDR_PRG2) begin
          // A count of zero passes the data through untouched
          push_event(EV_PRG,
                     (it.addr == ADDR_PRG0) ? 3'd0 : (it.addr == ADDR_PRG1) ? 3'd1 : 3'd2,
                     (bank_count == 9'd0) ? it.data
                                          : 8'(int'(it.data) % int'(bank_count)),
                     1'b1);
        end else if (it.addr == ADDR_MIRROR) begin
          push_event(EV_MIRROR, 3'd0, {7'd0, it.data[7]}, 1'b1);
        end else if (it.addr == ADDR_IRQ_CTRL) begin
          irq_armed = it.data[7];
          push_event(EV_ACK, 3'd0, 8'd0, 1'b1);
        end else begin
          if (it.addr == ADDR_IRQ_LOAD) begin
            irq_tally = int'(reload_value);
          end else if (it.addr == ADDR_RELOAD_H) begin
            reload_value[15:8] = it.data;
          end else if (it.addr == ADDR_RELOAD_L) begin
            reload_value[7:0] = it.data;
          end
          push_event(EV_NONE, 3'd0, 8'd0, 1'b1);
        end
      end
      OP_TICK: begin
        if (irq_armed) begin
          irq_tally = irq_tally - int'(it.cycles);
          // Fire only once the counter drops strictly below the floor, then park it
          if (irq_tally < -4) begin
            irq_armed = 1'b0;
            irq_tally = -1;
            raised    = 1'b1;
          end
        end
        push_event(raised ? EV_IRQ : EV_NONE, 3'd0, 8'd0, 1'b1);
      end
      default: begin
        push_event(EV_NONE, 3'd0, 8'd0, 1'b1);
      end
    endcase
  endtask

  task automatic push_item(input op_t op, input addr_t addr, input byte_t data,
                           input cycles_t cycles);
    bus_item_t it;
    it.op     = op;
    it.addr   = addr;
    it.data   = data;
    it.cycles = cycles;
    bus_items.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Hold until the block has taken every item and returned every event
  task automatic wait_quiet();
    while (bus_items.size() != 0 || due_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write in setup and access phases, then read the register back
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data,
                                input logic [31:0] mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == {REG_PRG_COUNT, 2'b00}) begin
      bank_count = data[8:0];
    end else begin
      mirror_vertical = data[0];
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (data & mask)) begin
      $error("register %0d: expected %0h, got %0h", addr, data & mask, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [8:0] count, input logic vertical);
    wait_quiet();
    write_register({REG_PRG_COUNT, 2'b00}, {23'd0, count}, 32'h1FF);
    write_register({REG_MIRROR, 2'b00}, {31'd0, vertical}, 32'h1);
    settings_used++;
  endtask

  // Random items: mostly interrupt programming runs and bank selects, some noise
  task automatic queue_random_items(input int count);
    int made;
    int pick;
    int ticks;
    logic [15:0] reload;
    addr_t addr;
    made = 0;
    push_item(OP_INIT, 16'($urandom), 8'($urandom), 16'($urandom));
    made++;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Program a reload, load and arm the counter, then count it down
        reload = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
        push_item(OP_WRITE, ADDR_RELOAD_H, reload[15:8], 16'($urandom));
        push_item(OP_WRITE, ADDR_RELOAD_L, reload[7:0], 16'($urandom));
        push_item(OP_WRITE, ADDR_IRQ_LOAD, 8'($urandom), 16'($urandom));
        push_item(OP_WRITE, ADDR_IRQ_CTRL, {1'($urandom_range(0, 4) != 0), 7'($urandom)},
                  16'($urandom));
        ticks = $urandom_range(1, 5);
        repeat (ticks) begin
          push_item(OP_TICK, 16'($urandom), 8'($urandom),
                    ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 70)));
        end
        made += 4 + ticks;
        if ($urandom_range(0, 1) == 1) begin
          push_item(OP_WRITE, ADDR_IRQ_CTRL, 8'($urandom), 16'($urandom));
          made++;
        end
      end else if (pick < 75) begin
        case ($urandom_range(0, 5))
          0: addr = ADDR_PRG0;
          1: addr = ADDR_PRG1;
          2: addr = ADDR_PRG2;
          3: addr = ADDR_CHR_BASE | 16'($urandom_range(0, 7));
          4: addr = ADDR_MIRROR;
          default: addr = ADDR_IRQ_CTRL;
        endcase
        push_item(OP_WRITE, addr, 8'($urandom), 16'($urandom));
        made++;
      end else if (pick < 82) begin
        push_item(OP_INIT, 16'($urandom), 8'($urandom), 16'($urandom));
        made++;
      end else begin
        case ($urandom_range(0, 3))
          0: push_item(OP_WRITE, 16'($urandom), 8'($urandom), 16'($urandom));
          1: push_item(OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
          2: push_item(OP_RESERVED, 16'($urandom), 8'($urandom), 16'($urandom));
          default: push_item(OP_WRITE, 16'h9000 | 16'($urandom_range(0, 7)), 8'($urandom),
                             16'($urandom));
        endcase
        made++;
      end
    end
  endtask

  // Sender: offer the head of the queue at the falling edge; once valid is up,
  // hold it and the payload until the transfer completes.
  always @(negedge clk) begin
    if (!rst_n || send_gap != 0 || bus_items.size() == 0) begin
      map_in.valid <= 1'b0;
    end else begin
      map_in.valid       <= 1'b1;
      map_in.operation   <= bus_items[0].op;
      map_in.bus_address <= bus_items[0].addr;
      map_in.write_data  <= bus_items[0].data;
      map_in.tick_cycles <= bus_items[0].cycles;
    end
  end

  // On each input transfer: predict its events, drop it from the queue and
  // pick the next gap once the current burst is spent.
  always @(posedge clk) begin
    if (rst_n && map_in.valid && map_in.ready) begin
      map_events(bus_items.pop_front());
      items_taken++;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 12);
        send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end else if (send_gap != 0) begin
      send_gap--;
    end
  end

  // Receiver: runs and stalls of random length, some runs with no stall at all,
  // and a long hold-off whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HoldoffCycles;
    end
    if (!rst_n) begin
      map_out.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      map_out.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      map_out.ready <= 1'b0;
    end else begin
      map_out.ready <= 1'b1;
      if (run_left != 0) begin
        run_left--;
      end else begin
        run_left   = $urandom_range(0, 20);
        stall_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  // Monitor: compare every output transfer with the oldest owed event
  always @(posedge clk) begin
    map_event_t want;
    if (rst_n && map_out.valid && map_out.ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected event: kind %0d slot %0d value %0d last %0d",
               map_out.event_kind, map_out.slot, map_out.value, map_out.last);
        error_count++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", 8'(want.kind), 8'(map_out.event_kind));
        check_field("slot", 8'(want.slot), 8'(map_out.slot));
        check_field("value", want.value, map_out.value);
        check_field("last", 8'(want.last), 8'(map_out.last));
        events_checked++;
        if (want.kind == EV_IRQ) irqs_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    logic [8:0] counts[7];
    counts = '{9'd256, 9'd3, 9'd1, 9'd0, 9'd37, 9'd511, 9'd2};

    // Drive every input to a known value before the first edge
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = 3'd0;
    pwdata             = 32'd0;
    map_in.valid       = 1'b0;
    map_in.operation   = OP_INIT;
    map_in.bus_address = 16'd0;
    map_in.write_data  = 8'd0;
    map_in.tick_cycles = 16'd0;
    map_out.ready      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration (two banks, horizontal)
    push_item(OP_INIT, 16'd0, 8'd0, 16'd0);
    push_item(OP_WRITE, ADDR_PRG0, 8'hFF, 16'd0);
    push_item(OP_WRITE, ADDR_PRG1, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_PRG2, 8'h81, 16'd0);
    push_item(OP_WRITE, ADDR_CHR_BASE, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_CHR_BASE | 16'd7, 8'hFF, 16'd0);
    push_item(OP_WRITE, ADDR_MIRROR, 8'h80, 16'd0);
    push_item(OP_WRITE, ADDR_MIRROR, 8'h7F, 16'd0);
    // Full reload: a full-size tick leaves the counter at zero
    push_item(OP_WRITE, ADDR_RELOAD_H, 8'hFF, 16'd0);
    push_item(OP_WRITE, ADDR_RELOAD_L, 8'hFF, 16'd0);
    push_item(OP_WRITE, ADDR_IRQ_LOAD, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_IRQ_CTRL, 8'h80, 16'd0);
    push_item(OP_TICK, 16'd0, 8'd0, 16'hFFFF);
    // Reaching the floor exactly stays quiet; a tick of one more fires
    push_item(OP_TICK, 16'd0, 8'd0, 16'd4);
    push_item(OP_TICK, 16'd0, 8'd0, 16'd1);
    // Disarmed after firing, so a huge tick does nothing
    push_item(OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF);
    push_item(OP_WRITE, ADDR_IRQ_CTRL, 8'h00, 16'hFFFF);
    // Unmapped addresses, the address just past the chr range, reserved op
    push_item(OP_WRITE, 16'h9000, 8'h55, 16'd0);
    push_item(OP_WRITE, 16'hFFFF, 8'hFF, 16'hFFFF);
    push_item(OP_WRITE, 16'hB008, 8'hAA, 16'd0);
    push_item(OP_RESERVED, 16'hFFFF, 8'hFF, 16'hFFFF);
    // Zero reload: arm and fire on a small tick
    push_item(OP_WRITE, ADDR_RELOAD_H, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_RELOAD_L, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_IRQ_LOAD, 8'h00, 16'd0);
    push_item(OP_WRITE, ADDR_IRQ_CTRL, 8'hFF, 16'd0);
    push_item(OP_TICK, 16'd0, 8'd0, 16'd5);
    push_item(OP_INIT, 16'hFFFF, 8'hFF, 16'hFFFF);

    // Random phases over several settings, extremes and odd counts included.
    // In the second phase hold the receiver off while the sender keeps
    // offering, so the block backs up and stalls its input.
    for (int p = 0; p < 7; p++) begin
      apply_setting(counts[p], 1'(p % 2 == 0));
      if (p == 1) begin
        @(posedge clk);
        holdoff_req++;
      end
      queue_random_items(25);
    end
    apply_setting(9'($urandom_range(2, 256)), 1'($urandom));
    queue_random_items(25);

    // Drain, then leave room for anything stray the block might still send
    wait_quiet();
    repeat (40) @(negedge clk);

    $display("covered %0d items and %0d events (%0d interrupts raised) over %0d settings",
             items_taken, events_checked, irqs_seen, settings_used);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/bsim_pkg.sv
sv/bsim_if.sv
sv/bank_switch_irq_mapper_unit.sv
test/testbench.sv
